/* src/rar_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_pkg: shared types and constants
// Opcodes, default widths and the controller/datapath command structs.
// ----------------------------------------------------------------------------
package rar_pkg;

  localparam int unsigned OperandWidthDef = 16;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } opcode_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // capture operands
    logic form;      // build raw parts from products
    logic gcd_init;  // load gcd registers
    logic gcd_step;  // one binary gcd step
    logic div_init;  // start the two divisions
    logic div_step;  // one restoring division bit
    logic finish;    // write result register
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic zero;      // a raw part is zero
    logic gcd_done;
    logic div_done;
  } dp_sts_t;

endpackage

/* src/rar_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_if: valid/ready channel
// Carries one payload of width W per beat.
// ----------------------------------------------------------------------------
interface rar_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/rar_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_dp: datapath
// Products, raw parts, binary gcd and two bit-serial divisions by the gcd.
// ----------------------------------------------------------------------------
module rar_dp #(
  parameter int unsigned OperandWidth = rar_pkg::OperandWidthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rar_pkg::dp_cmd_t          cmd_i,
  output rar_pkg::dp_sts_t          sts_o,
  input  logic [1:0]                opcode_i,
  input  logic [OperandWidth-1:0]   an_i,
  input  logic [OperandWidth-1:0]   ad_i,
  input  logic [OperandWidth-1:0]   bn_i,
  input  logic [OperandWidth-1:0]   bd_i,
  output logic [2*OperandWidth+1:0] res_n_o,
  output logic [2*OperandWidth+1:0] res_d_o
);
  localparam int unsigned W  = OperandWidth;
  localparam int unsigned PW = 2 * W;      // product magnitude
  localparam int unsigned RW = 2 * W + 2;  // result / raw magnitude
  localparam int unsigned CW = $clog2(RW + 1);

  logic [1:0]  op_q;
  logic [W:0]  an_q, ad_q, bn_q, bd_q;     // magnitudes, W+1 bits
  logic        ans_q, ads_q, bns_q, bds_q;

  function automatic logic [W:0] mag(input logic [W-1:0] v);
    logic [W:0] e;
    e = {v[W-1], v};
    return v[W-1] ? (~e + 1'b1) : e;
  endfunction

  // operand capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= opcode_i;
      an_q  <= mag(an_i);  ans_q <= an_i[W-1];
      ad_q  <= mag(ad_i);  ads_q <= ad_i[W-1];
      bn_q  <= mag(bn_i);  bns_q <= bn_i[W-1];
      bd_q  <= mag(bd_i);  bds_q <= bd_i[W-1];
    end
  end

  // products registered
  logic [PW+1:0] p1_q, p2_q, p3_q;
  logic          s1_q, s2_q, s3_q;
  logic [W:0]    m1a, m1b, m2b;
  logic          s1, s2;
  always_comb begin
    m1a = an_q; m1b = bd_q; s1 = ans_q ^ bds_q;
    m2b = bn_q; s2 = ads_q ^ bns_q;
    if (rar_pkg::opcode_e'(op_q) == rar_pkg::OP_MUL) begin
      m1b = bn_q; s1 = ans_q ^ bns_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      p1_q <= '0; p2_q <= '0; p3_q <= '0;
    end else if (!cmd_i.form && !cmd_i.gcd_init && !cmd_i.gcd_step &&
                 !cmd_i.div_init && !cmd_i.div_step && !cmd_i.finish) begin
      p1_q <= m1a * m1b;  s1_q <= s1;
      p2_q <= ad_q * m2b; s2_q <= s2;
      p3_q <= ad_q * bd_q; s3_q <= ads_q ^ bds_q;
    end
  end

  // raw parts
  logic [RW-1:0] n_q, d_q;
  logic          nn_q, dn_q;
  logic [RW-1:0] x1, x2;
  logic          xs2;
  always_comb begin
    x1 = RW'(p1_q);
    x2 = RW'(p2_q);
    xs2 = s2_q ^ (rar_pkg::opcode_e'(op_q) == rar_pkg::OP_SUB);
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.form) begin
      unique case (rar_pkg::opcode_e'(op_q))
        rar_pkg::OP_ADD, rar_pkg::OP_SUB: begin
          if (s1_q == xs2) begin
            n_q <= x1 + x2; nn_q <= s1_q;
          end else if (x1 >= x2) begin
            n_q <= x1 - x2; nn_q <= s1_q;
          end else begin
            n_q <= x2 - x1; nn_q <= xs2;
          end
          d_q <= RW'(p3_q); dn_q <= s3_q;
        end
        rar_pkg::OP_MUL: begin
          n_q <= x1; nn_q <= s1_q; d_q <= RW'(p3_q); dn_q <= s3_q;
        end
        rar_pkg::OP_DIV: begin
          n_q <= x1; nn_q <= s1_q; d_q <= x2; dn_q <= s2_q;
        end
        default: ;
      endcase
    end
  end

  // binary gcd: u, v, common power of two k
  logic [RW-1:0] u_q, v_q;
  logic [CW-1:0] k_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.gcd_init) begin
      u_q <= n_q; v_q <= d_q; k_q <= '0;
    end else if (cmd_i.gcd_step) begin
      if (!u_q[0] && !v_q[0]) begin
        u_q <= u_q >> 1; v_q <= v_q >> 1; k_q <= k_q + 1'b1;
      end else if (!u_q[0]) begin
        u_q <= u_q >> 1;
      end else if (!v_q[0]) begin
        v_q <= v_q >> 1;
      end else if (u_q >= v_q) begin
        u_q <= (u_q - v_q) >> 1;
      end else begin
        v_q <= (v_q - u_q) >> 1;
      end
    end
  end
  // gcd finished when u is zero; g = v << k

  // two restoring dividers sharing the divisor
  logic [RW-1:0] g_q, qn_q, qd_q, rn_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic [RW:0]   tn, td;
  always_comb begin
    tn = {rn_q, qn_q[RW-1]};
    td = {rd_q, qd_q[RW-1]};
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      g_q <= v_q << k_q;
      qn_q <= n_q; qd_q <= d_q; rn_q <= '0; rd_q <= '0;
      cnt_q <= CW'(RW);
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q - 1'b1;
      if (tn >= {1'b0, g_q}) begin
        rn_q <= RW'(tn - {1'b0, g_q}); qn_q <= {qn_q[RW-2:0], 1'b1};
      end else begin
        rn_q <= RW'(tn); qn_q <= {qn_q[RW-2:0], 1'b0};
      end
      if (td >= {1'b0, g_q}) begin
        rd_q <= RW'(td - {1'b0, g_q}); qd_q <= {qd_q[RW-2:0], 1'b1};
      end else begin
        rd_q <= RW'(td); qd_q <= {qd_q[RW-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      if (n_q == '0 || d_q == '0) begin
        res_n_o <= '0; res_d_o <= '0;
      end else begin
        res_n_o <= nn_q ? (~qn_q + 1'b1) : qn_q;
        res_d_o <= dn_q ? (~qd_q + 1'b1) : qd_q;
      end
    end
  end

  assign sts_o.zero     = (n_q == '0) || (d_q == '0);
  assign sts_o.gcd_done = (u_q == '0);
  assign sts_o.div_done = (cnt_q == '0);

  logic unused;
  assign unused = rst_ni;
endmodule

/* src/rar_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rar_ctrl: sequencer
// Steps the datapath through multiply, form, gcd, divide and output.
// ----------------------------------------------------------------------------
module rar_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output rar_pkg::dp_cmd_t cmd_o,
  input  rar_pkg::dp_sts_t sts_i
);
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_FORM = 8'b0000_0100,
    S_GINI = 8'b0000_1000,
    S_GCD  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ov_q, ov_d;

  // next state
  always_comb begin
    state_d = state_q;
    ov_d    = ov_q;
    cmd_o   = '0;
    if (out_valid_o && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1; state_d = S_MUL;
      end
      S_MUL:  state_d = S_FORM;
      S_FORM: begin
        cmd_o.form = 1'b1; state_d = S_GINI;
      end
      S_GINI: begin
        if (sts_i.zero) state_d = S_FIN;
        else begin
          cmd_o.gcd_init = 1'b1; state_d = S_GCD;
        end
      end
      S_GCD: begin
        if (sts_i.gcd_done) begin
          cmd_o.div_init = 1'b1; state_d = S_DIV;
        end else cmd_o.gcd_step = 1'b1;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_FIN;
        else cmd_o.div_step = 1'b1;
      end
      S_FIN: if (!ov_q || out_ready_i) begin
        cmd_o.finish = 1'b1; ov_d = 1'b1; state_d = S_IDLE;
      end
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

  // finish only when the output register is free or its result is being taken
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!ov_q || out_ready_i)) else $error("result overwritten");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == S_MUL) else $error("load sequencing");
  a_one_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
endmodule

/* src/rational_arith_reduce.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_reduce: fraction arithmetic with gcd reduction
// Usage:
//   in_i carries opcode and four signed operands per beat; out_o carries
//   the reduced numerator and denominator, 2*OPERAND_WIDTH+2 bits each.
//   One item is worked at a time. From accept to result valid it passes
//   through multiply, form, gcd init, the binary gcd loop, the two
//   bit-serial dividers of RW = 2*OPERAND_WIDTH+2 quotient bits and the
//   result write; the length of the gcd loop depends on the operands.
//   A zero raw part skips gcd and division and gives 0/0.
//   The next beat is accepted only once the result is written, so a new
//   item cannot start before the previous one is through.
//   The result sits in an output register; the next item is accepted while
//   it waits, and the block stalls before writing a second result until
//   the receiver takes the first.
//   Reset clears the controller and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module rational_arith_reduce #(
  parameter int unsigned OPERAND_WIDTH = rar_pkg::OperandWidthDef
) (
  input logic clk_i,
  input logic rst_ni,
  rar_if.sink   in_i,
  rar_if.source out_o
);
  localparam int unsigned W  = OPERAND_WIDTH;
  localparam int unsigned RW = 2 * W + 2;

  rar_pkg::dp_cmd_t cmd;
  rar_pkg::dp_sts_t sts;
  logic [RW-1:0] res_n, res_d;

  rar_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  rar_dp #(.OperandWidth(W)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i   (cmd),
    .sts_o   (sts),
    .opcode_i(in_i.data[4*W+1:4*W]),
    .an_i    (in_i.data[4*W-1:3*W]),
    .ad_i    (in_i.data[3*W-1:2*W]),
    .bn_i    (in_i.data[2*W-1:W]),
    .bd_i    (in_i.data[W-1:0]),
    .res_n_o (res_n),
    .res_d_o (res_d)
  );

  assign out_o.data = {res_n, res_d};
endmodule
